### hdl/tpd_pkg.sv
// Package for the torus point and derivatives block.
// Holds the word types, register indexes, fixed-point constants and the CORDIC angle table.
// No dependencies.
package tpd_pkg;

  localparam int CordicSteps  = 24;
  localparam int FractionBits = 16;
  localparam int ScaleFrac    = 24;
  localparam int TrigFrac     = 30;
  localparam int AngleShift   = FractionBits + ScaleFrac - TrigFrac;
  // Compare-and-subtract steps that reduce the angle modulo 2*pi; the scaled
  // angle stays below 2*pi times 2^22 once it is made non-negative.
  localparam int ReduceSteps  = 22;

  // Angle constants and the CORDIC gain in Q30.
  localparam logic signed [35:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [35:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [35:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;

  // Configuration register indexes.
  localparam logic [2:0] RegCenterX     = 3'd0;
  localparam logic [2:0] RegCenterY     = 3'd1;
  localparam logic [2:0] RegCenterZ     = 3'd2;
  localparam logic [2:0] RegMajorRadius = 3'd3;
  localparam logic [2:0] RegTubeRadius  = 3'd4;
  localparam logic [2:0] RegScaleFirst  = 3'd5;
  localparam logic [2:0] RegScaleSecond = 3'd6;

  // Axis codes.
  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef struct packed {
    logic signed [31:0] param_first;
    logic signed [31:0] param_second;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         axis;
    logic signed [31:0] position;
    logic signed [31:0] deriv_first;
    logic signed [31:0] second_deriv_first;
    logic signed [31:0] deriv_second;
    logic signed [31:0] second_deriv_second;
    logic               last_axis;
  } out_word_t;

  // Rotation angle atan(2^-i) in Q30.
  function automatic logic signed [35:0] atan_q30(input int i);
    logic signed [35:0] t;
    case (i)
      0: t = 36'sd843314857;
      1: t = 36'sd497837829;
      2: t = 36'sd263043837;
      3: t = 36'sd133525159;
      4: t = 36'sd67021687;
      5: t = 36'sd33543516;
      6: t = 36'sd16775851;
      7: t = 36'sd8388437;
      8: t = 36'sd4194283;
      9: t = 36'sd2097149;
      default: t = 36'sd1 <<< (30 - i);
    endcase
    return t;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sd2147483647) r = 32'sh7fffffff;
    else if (v < -36'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round v*t/2^30 to nearest, halves up; the product is registered by the caller.
  function automatic logic signed [35:0] round_q30(input logic signed [67:0] p);
    logic signed [67:0] s;
    s = p + (68'sd1 <<< (TrigFrac - 1));
    return s[65:30];
  endfunction

endpackage

### hdl/tpd_trig.sv
// Pipelined angle unit: scale, modulo 2*pi, quadrant fold and CORDIC, one stage per step.
// Depends on tpd_pkg.
module tpd_trig (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] w,
  input  logic signed [31:0] scale,
  output logic               out_valid,
  output logic signed [33:0] sn,
  output logic signed [33:0] cs
);
  import tpd_pkg::*;

  localparam int Stages = CordicSteps + 1;
  localparam logic signed [55:0] TwoPiWide = 56'(TwoPiQ30);

  // Stage A: product of parameter and scale.
  logic               prod_valid;
  logic signed [63:0] prod;
  // Stage B: angle in Q30, moved up by a multiple of 2*pi when negative.
  logic               ang_valid;
  logic signed [55:0] ang;
  // Stage D: folded into [-pi/2, pi/2].
  logic               fold_valid;
  logic signed [35:0] fold;
  logic               fold_flip;

  logic signed [55:0] shifted;
  logic signed [55:0] ang_next;
  logic signed [35:0] red;
  logic signed [35:0] centered;
  logic signed [35:0] fold_next;
  logic               flip_next;

  // Reduction chain: each stage subtracts 2*pi times a falling power of two if it fits.
  logic               rv [ReduceSteps+1];
  logic signed [55:0] rr [ReduceSteps+1];

  always_comb begin
    shifted  = 56'(prod >>> AngleShift);
    ang_next = (shifted < 0) ? shifted + (TwoPiWide <<< (ReduceSteps - 1)) : shifted;
  end

  always_comb begin
    rv[0] = ang_valid;
    rr[0] = ang;
  end

  for (genvar k = 0; k < ReduceSteps; k++) begin : g_reduce
    localparam logic signed [55:0] Step = TwoPiWide <<< (ReduceSteps - 1 - k);
    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else     rv[k+1] <= rv[k];
      rr[k+1] <= (rr[k] >= Step) ? rr[k] - Step : rr[k];
    end
  end

  // Map the remainder in [0, 2*pi) to (-pi, pi], then fold to the right half plane.
  always_comb begin
    red = rr[ReduceSteps][35:0];
    centered = (red > PiQ30) ? red - TwoPiQ30 : red;
    flip_next = 1'b0;
    fold_next = centered;
    if (centered > HalfPiQ30) begin
      fold_next = centered - PiQ30;
      flip_next = 1'b1;
    end else if (centered < -HalfPiQ30) begin
      fold_next = centered + PiQ30;
      flip_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      ang_valid  <= 1'b0;
      fold_valid <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      ang_valid  <= prod_valid;
      fold_valid <= rv[ReduceSteps];
    end
    prod      <= w * scale;
    ang       <= ang_next;
    fold      <= fold_next;
    fold_flip <= flip_next;
  end

  // CORDIC rotation stages, one step per register stage.
  logic               cv [Stages];
  logic signed [33:0] cx [Stages];
  logic signed [33:0] cy [Stages];
  logic signed [35:0] cr [Stages];
  logic               cf [Stages];

  always_comb begin
    cv[0] = fold_valid;
    cx[0] = GainQ30;
    cy[0] = '0;
    cr[0] = fold;
    cf[0] = fold_flip;
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) cv[i+1] <= 1'b0;
      else     cv[i+1] <= cv[i];
      cf[i+1] <= cf[i];
      if (cr[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cr[i+1] <= cr[i] - atan_q30(i);
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cr[i+1] <= cr[i] + atan_q30(i);
      end
    end
  end

  assign out_valid = cv[CordicSteps];
  assign sn = cf[CordicSteps] ? -cy[CordicSteps] : cy[CordicSteps];
  assign cs = cf[CordicSteps] ? -cx[CordicSteps] : cx[CordicSteps];

endmodule

### hdl/torus_point_and_derivatives_top.sv
// Top level of the torus point and derivatives block.
// Depends on tpd_pkg and tpd_trig.
//
// Use: drive item with (param_first, param_second) and raise start; the word
// is taken at a clock edge where start is high and busy is low. Each word
// yields three result words on result, marked by result_valid for one cycle
// each: axis x, y, then z with last_axis set. The receiver cannot stall.
// Configuration: cfg_write with cfg_index and cfg_data, written at once.
// Users write only while the block is idle; the block does not enforce it.
// Pacing: busy goes high after each accepted word and the next word waits
// until it falls, since the single result port carries three words.
// Pipeline: result_valid for the x word rises once an accepted word has
// passed 25 front-end stages (product, angle, 22 modulo steps and the
// fold), 24 CORDIC stages, 4 product stages, the axis sequencer and the
// output register; y and z follow in turn.
// Reset: control and configuration registers reset; the pipeline empties.
module torus_point_and_derivatives_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  tpd_pkg::in_word_t  item,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               result_valid,
  output tpd_pkg::out_word_t result
);
  import tpd_pkg::*;

  // Configuration registers.
  logic signed [31:0] center_x, center_y, center_z, scale_first, scale_second;
  logic [30:0]        major_radius, tube_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      center_z     <= '0;
      major_radius <= 31'd5242880;
      tube_radius  <= 31'd655360;
      scale_first  <= 32'sd16777216;
      scale_second <= 32'sd16777216;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegCenterX:     center_x     <= cfg_data;
        RegCenterY:     center_y     <= cfg_data;
        RegCenterZ:     center_z     <= cfg_data;
        RegMajorRadius: major_radius <= cfg_data[30:0];
        RegTubeRadius:  tube_radius  <= cfg_data[30:0];
        RegScaleFirst:  scale_first  <= cfg_data;
        RegScaleSecond: scale_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept pacing: busy holds off the next word while hold counts down.
  logic [1:0] hold;
  logic       accept;
  assign busy   = (hold != 2'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) hold <= 2'd0;
    else if (accept) hold <= 2'd2;
    else if (hold != 2'd0) hold <= hold - 2'd1;
  end

  // Angle units.
  logic               va, vb;
  logic signed [33:0] sa, ca, sb, cb;

  tpd_trig u_trig_a (
    .clk, .rst, .in_valid(accept), .w(item.param_first), .scale(scale_first),
    .out_valid(va), .sn(sa), .cs(ca));
  tpd_trig u_trig_b (
    .clk, .rst, .in_valid(accept), .w(item.param_second), .scale(scale_second),
    .out_valid(vb), .sn(sb), .cs(cb));

  // Product stage 1: tube radius times sine and cosine of b.
  logic               p1_valid;
  logic signed [67:0] p1_rc, p1_rs;
  logic signed [33:0] p1_sa, p1_ca;
  // Stage 2: rounded tube terms and ring.
  logic               p2_valid;
  logic signed [35:0] p2_rvc, p2_rvs, p2_ring;
  logic signed [33:0] p2_sa, p2_ca;
  // Stage 3: products with sine and cosine of a.
  logic               p3_valid;
  logic signed [67:0] p3_rca, p3_rsa, p3_sca, p3_ssa, p3_cca, p3_csa;
  logic signed [35:0] p3_rvc, p3_rvs;
  // Stage 4: rounded values.
  logic               p4_valid;
  logic signed [35:0] p4_rca, p4_rsa, p4_sca, p4_ssa, p4_cca, p4_csa, p4_rvc, p4_rvs;

  logic b_unused;
  assign b_unused = vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
    end else begin
      p1_valid <= va && b_unused;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
    end
    p1_rc   <= 68'($signed({1'b0, tube_radius})) * 68'(cb);
    p1_rs   <= 68'($signed({1'b0, tube_radius})) * 68'(sb);
    p1_sa   <= sa;
    p1_ca   <= ca;
    p2_rvc  <= round_q30(p1_rc);
    p2_rvs  <= round_q30(p1_rs);
    p2_ring <= 36'($signed({1'b0, major_radius})) + round_q30(p1_rc);
    p2_sa   <= p1_sa;
    p2_ca   <= p1_ca;
    p3_rca  <= 68'(p2_ring) * 68'(p2_ca);
    p3_rsa  <= 68'(p2_ring) * 68'(p2_sa);
    p3_sca  <= 68'(p2_rvs) * 68'(p2_ca);
    p3_ssa  <= 68'(p2_rvs) * 68'(p2_sa);
    p3_cca  <= 68'(p2_rvc) * 68'(p2_ca);
    p3_csa  <= 68'(p2_rvc) * 68'(p2_sa);
    p3_rvc  <= p2_rvc;
    p3_rvs  <= p2_rvs;
    p4_rca  <= round_q30(p3_rca);
    p4_rsa  <= round_q30(p3_rsa);
    p4_sca  <= round_q30(p3_sca);
    p4_ssa  <= round_q30(p3_ssa);
    p4_cca  <= round_q30(p3_cca);
    p4_csa  <= round_q30(p3_csa);
    p4_rvc  <= p3_rvc;
    p4_rvs  <= p3_rvs;
  end

  // Hold the finished values while the three axis words go out.
  logic [1:0]         axis_cnt;
  logic               sending;
  logic signed [35:0] h_rca, h_rsa, h_sca, h_ssa, h_cca, h_csa, h_rvc, h_rvs;

  always_ff @(posedge clk) begin
    if (rst) begin
      sending  <= 1'b0;
      axis_cnt <= AxisX;
    end else if (p4_valid) begin
      sending  <= 1'b1;
      axis_cnt <= AxisX;
    end else if (sending) begin
      if (axis_cnt == AxisZ) sending <= 1'b0;
      else axis_cnt <= axis_cnt + 2'd1;
    end
    if (p4_valid) begin
      h_rca <= p4_rca; h_rsa <= p4_rsa; h_sca <= p4_sca; h_ssa <= p4_ssa;
      h_cca <= p4_cca; h_csa <= p4_csa; h_rvc <= p4_rvc; h_rvs <= p4_rvs;
    end
  end

  // Output word register.
  out_word_t word_next;
  always_comb begin
    word_next.axis      = axis_cnt;
    word_next.last_axis = (axis_cnt == AxisZ);
    case (axis_cnt)
      AxisX: begin
        word_next.position            = sat32(h_rca + 36'(center_x));
        word_next.deriv_first         = sat32(-h_rsa);
        word_next.second_deriv_first  = sat32(-h_rca);
        word_next.deriv_second        = sat32(-h_sca);
        word_next.second_deriv_second = sat32(-h_cca);
      end
      AxisY: begin
        word_next.position            = sat32(h_rsa + 36'(center_y));
        word_next.deriv_first         = sat32(h_rca);
        word_next.second_deriv_first  = sat32(-h_rsa);
        word_next.deriv_second        = sat32(-h_ssa);
        word_next.second_deriv_second = sat32(-h_csa);
      end
      default: begin
        word_next.position            = sat32(h_rvs + 36'(center_z));
        word_next.deriv_first         = '0;
        word_next.second_deriv_first  = '0;
        word_next.deriv_second        = sat32(h_rvc);
        word_next.second_deriv_second = sat32(-h_rvs);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= sending;
    result <= word_next;
  end

endmodule
